// ===== hw/rtl/w2h_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package w2h_pkg;

   // Fixed field widths of the channels and the register file.
   localparam int unsigned ActionWidth   = 2;
   localparam int unsigned CoordWidth    = 32;
   localparam int unsigned WeightWidth   = 32;
   localparam int unsigned IndexWidth    = 6;
   localparam int unsigned StatusWidth   = 3;
   localparam int unsigned OutSumWidth   = 48;
   localparam int unsigned CountWidth    = 7;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;

   // Defaults for the top-level parameters.
   localparam int unsigned MaxBinsXDefault = 64;
   localparam int unsigned MaxBinsYDefault = 64;
   localparam int unsigned SumWidthDefault = 48;

   // Register reset values.
   localparam logic [CountWidth-1:0] BinCountReset  = 7'd64;
   localparam logic [CoordWidth-1:0] RangeLowReset  = 32'd0;
   localparam logic [CoordWidth-1:0] RangeHighReset = 32'd65536;

   typedef enum logic [ActionWidth-1:0] {
      ACT_ADD   = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [StatusWidth-1:0] {
      STS_ADDED     = 3'd0,
      STS_FILTERED  = 3'd1,
      STS_OUT_RANGE = 3'd2,
      STS_BAD_RANGE = 3'd3,
      STS_READ      = 3'd4,
      STS_CLEARED   = 3'd5
   } status_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_BIN_COUNT_X  = 3'd0,
      CSR_BIN_COUNT_Y  = 3'd1,
      CSR_RANGE_X_LOW  = 3'd2,
      CSR_RANGE_X_HIGH = 3'd3,
      CSR_RANGE_Y_LOW  = 3'd4,
      CSR_RANGE_Y_HIGH = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_RD_ISSUE,
      ST_ACCESS,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/w2h_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface w2h_req_if;
   logic                                valid;
   logic                                ready;
   logic [w2h_pkg::ActionWidth-1:0]     action;
   logic signed [w2h_pkg::CoordWidth-1:0] value_x;
   logic signed [w2h_pkg::CoordWidth-1:0] value_y;
   logic [w2h_pkg::WeightWidth-1:0]     weight;
   logic                                keep;
   logic [w2h_pkg::IndexWidth-1:0]      read_row;
   logic [w2h_pkg::IndexWidth-1:0]      read_col;

   modport source (output valid, action, value_x, value_y, weight, keep, read_row, read_col,
                   input ready);
   modport sink   (input valid, action, value_x, value_y, weight, keep, read_row, read_col,
                   output ready);
endinterface

interface w2h_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [w2h_pkg::StatusWidth-1:0]    status;
   logic [w2h_pkg::OutSumWidth-1:0]    bin_sum;
   logic [w2h_pkg::IndexWidth-1:0]     row_index;
   logic [w2h_pkg::IndexWidth-1:0]     col_index;

   modport source (output valid, status, bin_sum, row_index, col_index, input ready);
   modport sink   (input valid, status, bin_sum, row_index, col_index, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/w2h_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module w2h_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                  clock,
   input  wire logic                  we,
   input  wire logic [AW-1:0]         waddr,
   input  wire logic [WIDTH-1:0]      wdata,
   input  wire logic                  re,
   input  wire logic [AW-1:0]         raddr,
   output logic      [WIDTH-1:0]      rdata
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/w2h_bin_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bin index of one axis: floor(offset * count / span), one quotient bit per cycle
// after a multiply step. The caller guarantees offset < span.
module w2h_bin_div #(
   parameter int unsigned MAX_BINS = w2h_pkg::MaxBinsXDefault
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [w2h_pkg::CoordWidth-1:0]        offset,
   input  wire logic [w2h_pkg::CoordWidth-1:0]        span,
   input  wire logic [NW-1:0]                         count,
   output logic                                       busy,
   output logic      [RW-1:0]                         bin
);
   localparam int unsigned RW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int unsigned NW  = $clog2(MAX_BINS + 1);
   localparam int unsigned RMW = w2h_pkg::CoordWidth + NW;
   localparam int unsigned SW  = $clog2(RW + 1);

   logic                               busy_ff, busy_in;
   logic                               mul_ff, mul_in;
   logic [w2h_pkg::CoordWidth-1:0]     off_ff, off_in;
   logic [NW-1:0]                      n_ff, n_in;
   logic [RMW-1:0]                     rem_ff, rem_in;
   logic [RMW-1:0]                     den_ff, den_in;
   logic [RW-1:0]                      quo_ff, quo_in;
   logic [SW-1:0]                      step_ff, step_in;
   logic [RMW-1:0]                     prod;
   logic                               fits;
   logic [NW-1:0]                      last_bin;

   assign prod     = RMW'(off_ff) * RMW'(n_ff);
   assign fits     = (rem_ff >= den_ff);
   assign last_bin = n_ff - NW'(1);

   always_comb begin
      busy_in = busy_ff;
      mul_in  = mul_ff;
      off_in  = off_ff;
      n_in    = n_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         mul_in  = 1'b1;
         off_in  = offset;
         n_in    = count;
         den_in  = RMW'(span) << (RW - 1);
         quo_in  = '0;
         step_in = SW'(RW);
      end else if (mul_ff) begin
         mul_in = 1'b0;
         rem_in = prod;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - den_ff;
         end
         den_in  = den_ff >> 1;
         quo_in  = (quo_ff << 1) | RW'(fits);
         step_in = step_ff - SW'(1);
         if (step_ff == SW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         mul_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         mul_ff  <= mul_in;
         step_ff <= step_in;
      end
      off_ff <= off_in;
      n_ff   <= n_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign bin  = (NW'(quo_ff) > last_bin) ? RW'(last_bin) : quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/weighted_2d_histogram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake         Carries
// req_chan  in   valid/ready       action, value_x, value_y, weight, keep, read_row, read_col
// rsp_chan  out  valid/ready       status, bin_sum, row_index, col_index
// csr_*     in   csr_we, no wait   csr_index selects one of six registers, csr_wdata
//
// One item is in work at a time. An add gets a range check; if it passes, a multiply and
// one quotient bit per cycle in each axis divider follow, then a read and a write-back
// of the bin RAM. A read issues the RAM read, then takes the data into the result.
// A clear, and the sweep that follows reset, write one RAM entry per cycle through all
// MAX_BINS_X*MAX_BINS_Y entries (4096 by default); no item is accepted meanwhile.
// A finished result sits in the output register while the next item is taken in.
// Reset is synchronous and active high.
module weighted_2d_histogram #(
   parameter int unsigned MAX_BINS_X = w2h_pkg::MaxBinsXDefault,
   parameter int unsigned MAX_BINS_Y = w2h_pkg::MaxBinsYDefault,
   parameter int unsigned SUM_WIDTH  = w2h_pkg::SumWidthDefault
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   w2h_req_if.sink                                   req_chan,
   w2h_rsp_if.source                                 rsp_chan,
   input  wire logic                                 csr_we,
   input  wire logic [w2h_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [w2h_pkg::CsrDataWidth-1:0]     csr_wdata
);
   localparam int unsigned Depth = MAX_BINS_X * MAX_BINS_Y;
   localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned RXW   = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
   localparam int unsigned RYW   = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
   localparam int unsigned NXW   = $clog2(MAX_BINS_X + 1);
   localparam int unsigned NYW   = $clog2(MAX_BINS_Y + 1);
   localparam int unsigned ExtW  = (SUM_WIDTH > w2h_pkg::OutSumWidth) ?
                                   SUM_WIDTH : w2h_pkg::OutSumWidth;
   localparam int unsigned CW    = w2h_pkg::CoordWidth;
   localparam int unsigned OSW   = w2h_pkg::OutSumWidth;
   localparam int unsigned IW    = w2h_pkg::IndexWidth;

   // Configuration registers.
   logic [w2h_pkg::CountWidth-1:0] bin_count_x_ff, bin_count_y_ff;
   logic signed [CW-1:0]           range_x_low_ff, range_x_high_ff;
   logic signed [CW-1:0]           range_y_low_ff, range_y_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_x_ff  <= w2h_pkg::BinCountReset;
         bin_count_y_ff  <= w2h_pkg::BinCountReset;
         range_x_low_ff  <= w2h_pkg::RangeLowReset;
         range_x_high_ff <= w2h_pkg::RangeHighReset;
         range_y_low_ff  <= w2h_pkg::RangeLowReset;
         range_y_high_ff <= w2h_pkg::RangeHighReset;
      end else if (csr_we) begin
         case (w2h_pkg::csr_index_type'(csr_index))
            w2h_pkg::CSR_BIN_COUNT_X:  bin_count_x_ff  <= csr_wdata[w2h_pkg::CountWidth-1:0];
            w2h_pkg::CSR_BIN_COUNT_Y:  bin_count_y_ff  <= csr_wdata[w2h_pkg::CountWidth-1:0];
            w2h_pkg::CSR_RANGE_X_LOW:  range_x_low_ff  <= csr_wdata;
            w2h_pkg::CSR_RANGE_X_HIGH: range_x_high_ff <= csr_wdata;
            w2h_pkg::CSR_RANGE_Y_LOW:  range_y_low_ff  <= csr_wdata;
            w2h_pkg::CSR_RANGE_Y_HIGH: range_y_high_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Bin counts in use, limited to the size of the store.
   logic [NXW-1:0] count_x;
   logic [NYW-1:0] count_y;

   assign count_x = (int'(bin_count_x_ff) > int'(MAX_BINS_X)) ?
                    NXW'(MAX_BINS_X) : NXW'(bin_count_x_ff);
   assign count_y = (int'(bin_count_y_ff) > int'(MAX_BINS_Y)) ?
                    NYW'(MAX_BINS_Y) : NYW'(bin_count_y_ff);

   // Captured item.
   w2h_pkg::action_type   act_ff, act_in;
   logic signed [CW-1:0]  vx_ff, vx_in;
   logic signed [CW-1:0]  vy_ff, vy_in;
   logic [w2h_pkg::WeightWidth-1:0] w_ff, w_in;
   logic                  keep_ff, keep_in;
   logic [IW-1:0]         rrow_ff, rrow_in;
   logic [IW-1:0]         rcol_ff, rcol_in;

   // Control and pending result.
   w2h_pkg::state_type    state_ff, state_in;
   logic [AddrW-1:0]      clr_addr_ff, clr_addr_in;
   logic                  clr_rsp_ff, clr_rsp_in;
   logic [AddrW-1:0]      addr_ff, addr_in;
   logic [IW-1:0]         row_ff, row_in;
   logic [IW-1:0]         col_ff, col_in;
   logic                  rd_ok_ff, rd_ok_in;
   w2h_pkg::status_type   res_status_ff, res_status_in;
   logic [OSW-1:0]        res_sum_ff, res_sum_in;
   logic [IW-1:0]         res_row_ff, res_row_in;
   logic [IW-1:0]         res_col_ff, res_col_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [w2h_pkg::StatusWidth-1:0] rsp_status_ff, rsp_status_in;
   logic [OSW-1:0]        rsp_sum_ff, rsp_sum_in;
   logic [IW-1:0]         rsp_row_ff, rsp_row_in;
   logic [IW-1:0]         rsp_col_ff, rsp_col_in;

   // Memory and divider connections.
   logic                  ram_we, ram_re;
   logic [AddrW-1:0]      ram_waddr, ram_raddr;
   logic [SUM_WIDTH-1:0]  ram_wdata, ram_rdata;
   logic                  div_start;
   logic                  div_x_busy, div_y_busy;
   logic [RXW-1:0]        bin_x;
   logic [RYW-1:0]        bin_y;
   logic [CW-1:0]         off_x, off_y, span_x, span_y;

   // Range checks and offsets of the captured sample.
   logic                  bad_range, out_range;
   logic [SUM_WIDTH:0]    acc;
   logic [SUM_WIDTH-1:0]  sat_sum;
   logic [ExtW-1:0]       sat_ext, rd_ext;
   logic                  rsp_free;

   assign bad_range = (count_x == '0) || (count_y == '0) ||
                      (range_x_high_ff <= range_x_low_ff) ||
                      (range_y_high_ff <= range_y_low_ff);
   assign out_range = (vx_ff < range_x_low_ff) || (vx_ff >= range_x_high_ff) ||
                      (vy_ff < range_y_low_ff) || (vy_ff >= range_y_high_ff);
   assign off_x     = CW'(vx_ff - range_x_low_ff);
   assign off_y     = CW'(vy_ff - range_y_low_ff);
   assign span_x    = CW'(range_x_high_ff - range_x_low_ff);
   assign span_y    = CW'(range_y_high_ff - range_y_low_ff);

   // Saturating update of the bin just read.
   assign acc     = {1'b0, ram_rdata} + (SUM_WIDTH + 1)'(w_ff);
   assign sat_sum = acc[SUM_WIDTH] ? '1 : acc[SUM_WIDTH-1:0];
   assign sat_ext = ExtW'(sat_sum);
   assign rd_ext  = ExtW'(ram_rdata);

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      clr_rsp_in    = clr_rsp_ff;
      addr_in       = addr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      rd_ok_in      = rd_ok_ff;
      res_status_in = res_status_ff;
      res_sum_in    = res_sum_ff;
      res_row_in    = res_row_ff;
      res_col_in    = res_col_ff;
      act_in        = act_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      w_in          = w_ff;
      keep_in       = keep_ff;
      rrow_in       = rrow_ff;
      rcol_in       = rcol_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      req_chan.ready = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = addr_ff;
      ram_wdata     = sat_sum;
      ram_re        = 1'b0;
      ram_raddr     = addr_ff;
      div_start     = 1'b0;

      unique case (state_ff)
         w2h_pkg::ST_CLEAR: begin
            // Sweep zeros through the store, one entry per cycle.
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + AddrW'(1);
            if (clr_addr_ff == AddrW'(Depth - 1)) begin
               clr_addr_in = '0;
               clr_rsp_in  = 1'b0;
               if (clr_rsp_ff) begin
                  res_status_in = w2h_pkg::STS_CLEARED;
                  res_sum_in    = '0;
                  res_row_in    = '0;
                  res_col_in    = '0;
                  state_in      = w2h_pkg::ST_RESULT;
               end else begin
                  state_in = w2h_pkg::ST_IDLE;
               end
            end
         end
         w2h_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               act_in  = w2h_pkg::action_type'(req_chan.action);
               vx_in   = req_chan.value_x;
               vy_in   = req_chan.value_y;
               w_in    = req_chan.weight;
               keep_in = req_chan.keep;
               rrow_in = req_chan.read_row;
               rcol_in = req_chan.read_col;
               case (w2h_pkg::action_type'(req_chan.action))
                  w2h_pkg::ACT_ADD:   state_in = w2h_pkg::ST_CHECK;
                  w2h_pkg::ACT_READ:  state_in = w2h_pkg::ST_RD_ISSUE;
                  w2h_pkg::ACT_CLEAR: begin
                     clr_rsp_in = 1'b1;
                     state_in   = w2h_pkg::ST_CLEAR;
                  end
                  default: begin
                     // The unused action code is consumed without a result.
                  end
               endcase
            end
         end
         w2h_pkg::ST_CHECK: begin
            res_sum_in = '0;
            res_row_in = '0;
            res_col_in = '0;
            priority if (bad_range) begin
               res_status_in = w2h_pkg::STS_BAD_RANGE;
               state_in      = w2h_pkg::ST_RESULT;
            end else if (!keep_ff) begin
               res_status_in = w2h_pkg::STS_FILTERED;
               state_in      = w2h_pkg::ST_RESULT;
            end else if (out_range) begin
               res_status_in = w2h_pkg::STS_OUT_RANGE;
               state_in      = w2h_pkg::ST_RESULT;
            end else begin
               div_start = 1'b1;
               state_in  = w2h_pkg::ST_DIV;
            end
         end
         w2h_pkg::ST_DIV: begin
            if (!div_x_busy && !div_y_busy) begin
               addr_in   = AddrW'(int'(bin_x) * int'(MAX_BINS_Y) + int'(bin_y));
               row_in    = IW'(bin_x);
               col_in    = IW'(bin_y);
               ram_re    = 1'b1;
               ram_raddr = addr_in;
               state_in  = w2h_pkg::ST_ACCESS;
            end
         end
         w2h_pkg::ST_RD_ISSUE: begin
            rd_ok_in  = (int'(rrow_ff) < int'(MAX_BINS_X)) &&
                        (int'(rcol_ff) < int'(MAX_BINS_Y));
            addr_in   = AddrW'(int'(rrow_ff) * int'(MAX_BINS_Y) + int'(rcol_ff));
            row_in    = rrow_ff;
            col_in    = rcol_ff;
            ram_re    = rd_ok_in;
            ram_raddr = addr_in;
            state_in  = w2h_pkg::ST_ACCESS;
         end
         w2h_pkg::ST_ACCESS: begin
            // Read data of the addressed bin is valid in this cycle.
            res_row_in = row_ff;
            res_col_in = col_ff;
            if (act_ff == w2h_pkg::ACT_ADD) begin
               ram_we        = 1'b1;
               res_status_in = w2h_pkg::STS_ADDED;
               res_sum_in    = sat_ext[OSW-1:0];
            end else begin
               res_status_in = w2h_pkg::STS_READ;
               res_sum_in    = rd_ok_ff ? rd_ext[OSW-1:0] : '0;
            end
            state_in = w2h_pkg::ST_RESULT;
         end
         w2h_pkg::ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_sum_in    = res_sum_ff;
               rsp_row_in    = res_row_ff;
               rsp_col_in    = res_col_ff;
               state_in      = w2h_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = w2h_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= w2h_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff        <= act_in;
      vx_ff         <= vx_in;
      vy_ff         <= vy_in;
      w_ff          <= w_in;
      keep_ff       <= keep_in;
      rrow_ff       <= rrow_in;
      rcol_ff       <= rcol_in;
      addr_ff       <= addr_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      rd_ok_ff      <= rd_ok_in;
      res_status_ff <= res_status_in;
      res_sum_ff    <= res_sum_in;
      res_row_ff    <= res_row_in;
      res_col_ff    <= res_col_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.bin_sum   = rsp_sum_ff;
   assign rsp_chan.row_index = rsp_row_ff;
   assign rsp_chan.col_index = rsp_col_ff;

   w2h_bin_div #(
      .MAX_BINS (MAX_BINS_X)
   ) u_div_x (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .offset (off_x),
      .span   (span_x),
      .count  (count_x),
      .busy   (div_x_busy),
      .bin    (bin_x)
   );

   w2h_bin_div #(
      .MAX_BINS (MAX_BINS_Y)
   ) u_div_y (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .offset (off_y),
      .span   (span_y),
      .count  (count_y),
      .busy   (div_y_busy),
      .bin    (bin_y)
   );

   w2h_ram #(
      .WIDTH (SUM_WIDTH),
      .DEPTH (Depth)
   ) u_bin_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // The store is never written while an item may be taken in.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == w2h_pkg::ST_IDLE) |-> !ram_we)
      else $error("bin store written while idle");

   // A write-back goes to the entry that was read in the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == w2h_pkg::ST_ACCESS) |->
         ($past(ram_re) && $past(ram_raddr) == ram_waddr))
      else $error("write-back address differs from read address");

   // The clearing sweep advances by one entry per cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == w2h_pkg::ST_CLEAR && clr_addr_ff != AddrW'(Depth - 1)) |=>
         (state_ff == w2h_pkg::ST_CLEAR && clr_addr_ff == $past(clr_addr_ff) + AddrW'(1)))
      else $error("clear sweep skipped or left early");

   // The bin address is taken only after both dividers have finished.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == w2h_pkg::ST_DIV && ram_re) |-> (!div_x_busy && !div_y_busy))
      else $error("bin address used before division finished");

endmodule

`default_nettype wire
